// File: sv/bke_pkg.sv
// bke_pkg: shared types and constants for the b-spline kernel evaluator
// used by bspline_kernel_eval, bke_checker and the testbench; no dependencies
package bke_pkg;

  // field widths
  localparam int PosW = 16;           // position, signed q3.12
  localparam int OutW = 16;           // results, signed q2.13
  localparam int OrdW = 2;            // spline order register
  localparam int VW   = PosW + 1;     // |x|, holds +32768
  localparam int UW   = 13;           // segment-local abscissa, 0..4096
  localparam int SqW  = 2 * UW - 1;   // u^2 <= 2^24
  localparam int OpW  = UW + 1;       // second multiplier operand, <= 8192
  localparam int PrW  = SqW + OpW;    // u^3 or u^2 * (2 - u)
  localparam int AccW = PrW + 1;      // cubic numerator
  localparam int QLsb = 24;           // numerator / 2^24
  localparam int QW   = 15;           // quotient before the divide by three
  localparam int PW   = 27;           // 16384 u - 3 u^2
  localparam int RecipW     = 16;
  localparam int RecipShift = 17;

  // position breakpoints, q3.12
  localparam logic signed [VW-1:0] XHalf      = 17'sd2048;
  localparam logic signed [VW-1:0] XOne       = 17'sd4096;
  localparam logic signed [VW-1:0] XThreeHalf = 17'sd6144;
  localparam logic signed [VW-1:0] XTwo       = 17'sd8192;

  // result constants, q2.13
  localparam logic signed [OutW-1:0] OneQ13      = 16'sd8192;
  localparam logic signed [OutW-1:0] MinusTwoQ13 = -16'sd16384;

  // rounding and scaling constants
  localparam logic [SqW:0]    HalfQ12      = 26'd2048;
  localparam logic [SqW-1:0]  QuadMidNum   = 25'd12583936;       // 1.5 * 2^23 + 2^10
  localparam logic [PW-1:0]   HalfQ12P     = 27'd2048;
  localparam logic [AccW-1:0] CubeRound    = 40'h00_0180_0000;   // 3 * 2^23
  localparam logic [AccW-1:0] CubeInnerNum = 40'h40_0180_0000;   // 2^38 + 3 * 2^23
  localparam logic [RecipW-1:0] Recip3     = 16'd43691;          // ceil(2^17 / 3)

  typedef enum logic [OrdW-1:0] {
    ORDER_NONE   = 2'd0,
    ORDER_LINEAR = 2'd1,
    ORDER_QUAD   = 2'd2,
    ORDER_CUBIC  = 2'd3
  } order_e;

  localparam order_e OrderReset = ORDER_CUBIC;

  // which polynomial piece an item falls on
  typedef enum logic [2:0] {
    MODE_ZERO = 3'd0,
    MODE_LIN  = 3'd1,
    MODE_QOUT = 3'd2,
    MODE_QMID = 3'd3,
    MODE_CIN  = 3'd4,
    MODE_COUT = 3'd5
  } mode_e;

  typedef struct packed {
    mode_e          mode;
    logic           neg;   // x >= 0, odd derivative takes a minus sign
    logic [UW-1:0]  u;
  } seg_t;

endpackage

// File: sv/bspline_kernel_eval.sv
// bspline_kernel_eval: centred b-spline kernel, first and second derivative
// five-stage pipeline, at most one multiplier per stage; depends on bke_pkg
// throughput: one beat per cycle, limited by nothing but result_ready_i
// a stall holds every full stage; bubbles are squeezed out as the pipe refills
// rst_ni clears all valid bits and sets the order to cubic, datapath carries no reset
module bspline_kernel_eval
  import bke_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration
  input  logic                   spline_order_we_i,
  input  logic [OrdW-1:0]        spline_order_i,
  // position beats
  input  logic                   position_valid_i,
  output logic                   position_ready_o,
  input  logic signed [PosW-1:0] position_i,
  // result beats
  output logic                   result_valid_o,
  input  logic                   result_ready_i,
  output logic signed [OutW-1:0] kernel_value_o,
  output logic signed [OutW-1:0] first_derivative_o,
  output logic signed [OutW-1:0] second_derivative_o
);

  localparam int NumStages = 5;

  order_e order_q;

  logic [NumStages-1:0] valid_q;
  logic [NumStages-1:0] adv;

  // stage payloads
  seg_t seg1_q, seg2_q, seg3_q;
  seg_t seg1_d;
  logic [SqW-1:0] sq2_q, sq3_q;
  logic [PrW-1:0] pr3_q;
  logic [QW-1:0]  quo4_q;
  logic           cubic4_q;
  logic signed [OutW-1:0] b4_q, d14_q, d24_q;

  // ---------------------------------------------------------------------------
  // configuration register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= OrderReset;
    end else if (spline_order_we_i) begin
      order_q <= order_e'(spline_order_i);
    end
  end

  // ---------------------------------------------------------------------------
  // flow control: a stage moves on when it is empty or its successor moves
  // ---------------------------------------------------------------------------
  always_comb begin
    adv[NumStages-1] = !valid_q[NumStages-1] || result_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      adv[k] = !valid_q[k] || adv[k+1];
    end
  end

  assign position_ready_o = adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (adv[0]) begin
        valid_q[0] <= position_valid_i;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (adv[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: pick the polynomial piece and the local abscissa u
  // every piece is written in terms of u in 0..4096 so one squarer and
  // one cuber serve all orders
  // ---------------------------------------------------------------------------
  logic signed [VW-1:0] pos_x;
  logic [VW-1:0]        pos_v;

  assign pos_x = {position_i[PosW-1], position_i};
  assign pos_v = position_i[PosW-1] ? VW'(-pos_x) : VW'(pos_x);

  always_comb begin
    seg1_d.mode = MODE_ZERO;
    seg1_d.neg  = !position_i[PosW-1];
    seg1_d.u    = '0;
    case (order_q)
      ORDER_LINEAR: begin
        // [-1, 1), tent of height one
        if (pos_x >= -XOne && pos_x < XOne) begin
          seg1_d.mode = MODE_LIN;
          seg1_d.u    = UW'(VW'(XOne) - pos_v);
        end
      end
      ORDER_QUAD: begin
        if (pos_x >= -XThreeHalf && pos_x < -XHalf) begin
          seg1_d.mode = MODE_QOUT;
          seg1_d.u    = UW'(pos_x + XThreeHalf);
        end else if (pos_x >= -XHalf && pos_x < XHalf) begin
          seg1_d.mode = MODE_QMID;
          seg1_d.u    = UW'(pos_v);
        end else if (pos_x >= XHalf && pos_x < XThreeHalf) begin
          seg1_d.mode = MODE_QOUT;
          seg1_d.u    = UW'(XThreeHalf - pos_x);
        end
      end
      ORDER_CUBIC: begin
        // symmetric pieces; |x| == 1 falls on the outer piece, both agree there
        if (pos_v < VW'(XOne)) begin
          seg1_d.mode = MODE_CIN;
          seg1_d.u    = UW'(pos_v);
        end else if (pos_v < VW'(XTwo)) begin
          seg1_d.mode = MODE_COUT;
          seg1_d.u    = UW'(VW'(XTwo) - pos_v);
        end
      end
      default: begin
        seg1_d.mode = MODE_ZERO;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      seg1_q <= seg1_d;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: u^2
  // ---------------------------------------------------------------------------
  logic [SqW-1:0] sq_d;

  assign sq_d = SqW'(seg1_q.u) * SqW'(seg1_q.u);

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      seg2_q <= seg1_q;
      sq2_q  <= sq_d;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: inner cubic needs u^2 (2 - u), outer cubic needs u^3
  // ---------------------------------------------------------------------------
  logic [OpW-1:0] mul_op;
  logic [PrW-1:0] pr_d;

  assign mul_op = (seg2_q.mode == MODE_CIN) ? OpW'(XTwo) - OpW'(seg2_q.u)
                                            : OpW'(seg2_q.u);
  assign pr_d   = PrW'(sq2_q) * PrW'(mul_op);

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      seg3_q <= seg2_q;
      sq3_q  <= sq2_q;
      pr3_q  <= pr_d;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 4: rounded derivatives, quadratic and linear values, and the cubic
  // numerator scaled down by 2^24 ready for the divide by three
  // ---------------------------------------------------------------------------
  logic [AccW-1:0] cube_num;
  logic [QW-1:0]   quo_d;
  logic [SqW:0]    sq_rnd;      // u^2 + 1/2 lsb of q12
  logic [SqW-1:0]  qmid_num;
  logic [PW-1:0]   cin_p;
  logic [PW-1:0]   cin_rnd;
  logic signed [OutW-1:0] sq_r12, qmid_b, cin_mag;
  logic signed [OutW-1:0] u_s;
  logic signed [OutW-1:0] b_d, d1_mag, d1_d, d2_d;

  always_comb begin
    if (seg3_q.mode == MODE_CIN) begin
      // 2^38 - 3 u^2 (2 - u), rounding bias folded in
      cube_num = CubeInnerNum - ({pr3_q, 1'b0} + AccW'(pr3_q));
    end else begin
      cube_num = AccW'(pr3_q) + CubeRound;
    end
  end

  assign quo_d    = cube_num[QLsb +: QW];
  assign sq_rnd   = (SqW+1)'(sq3_q) + HalfQ12;
  assign sq_r12   = OutW'(sq_rnd >> 12);
  assign qmid_num = QuadMidNum - sq3_q;
  assign qmid_b   = OutW'(qmid_num >> 11);
  assign cin_p    = (PW'(seg3_q.u) << 14) - (PW'(sq3_q) + (PW'(sq3_q) << 1));
  assign cin_rnd  = cin_p + HalfQ12P;
  assign cin_mag  = OutW'(cin_rnd >> 12);
  assign u_s      = OutW'(seg3_q.u);

  always_comb begin
    b_d    = '0;
    d1_mag = '0;
    d2_d   = '0;
    case (seg3_q.mode)
      MODE_LIN: begin
        b_d    = u_s <<< 1;
        d1_mag = OneQ13;
      end
      MODE_QOUT: begin
        b_d    = sq_r12;
        d1_mag = u_s <<< 1;
        d2_d   = OneQ13;
      end
      MODE_QMID: begin
        b_d    = qmid_b;
        d1_mag = u_s <<< 2;
        d2_d   = MinusTwoQ13;
      end
      MODE_CIN: begin
        d1_mag = cin_mag;
        d2_d   = (u_s <<< 2) + (u_s <<< 1) + MinusTwoQ13;
      end
      MODE_COUT: begin
        d1_mag = sq_r12;
        d2_d   = u_s <<< 1;
      end
      default: begin
        b_d = '0;
      end
    endcase
  end

  // odd derivative: slope is negative on the right-hand side
  assign d1_d = seg3_q.neg ? -d1_mag : d1_mag;

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      quo4_q   <= quo_d;
      cubic4_q <= (seg3_q.mode == MODE_CIN) || (seg3_q.mode == MODE_COUT);
      b4_q     <= b_d;
      d14_q    <= d1_d;
      d24_q    <= d2_d;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 5: cubic value = floor(q / 3) by reciprocal multiply, output register
  // ---------------------------------------------------------------------------
  logic [QW+RecipW-1:0]   recip_prod;
  logic signed [OutW-1:0] kernel_d;

  assign recip_prod = (QW+RecipW)'(quo4_q) * (QW+RecipW)'(Recip3);
  assign kernel_d   = cubic4_q ? OutW'(recip_prod >> RecipShift) : b4_q;

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      kernel_value_o      <= kernel_d;
      first_derivative_o  <= d14_q;
      second_derivative_o <= d24_q;
    end
  end

  assign result_valid_o = valid_q[NumStages-1];

endmodule

// File: sv/bke_checker.sv
// bke_checker: port-level checks on the b-spline kernel evaluator
// bound to bspline_kernel_eval; depends on bke_pkg
module bke_checker
  import bke_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   position_valid_i,
  input logic                   position_ready_o,
  input logic                   result_valid_o,
  input logic                   result_ready_i,
  input logic signed [OutW-1:0] kernel_value_o,
  input logic signed [OutW-1:0] first_derivative_o,
  input logic signed [OutW-1:0] second_derivative_o
);

  logic in_beat;
  assign in_beat = position_valid_i && position_ready_o;

  // a stalled result beat holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_ready_i |=> result_valid_o
      && $stable(kernel_value_o) && $stable(first_derivative_o)
      && $stable(second_derivative_o))
    else $error("result beat changed while stalled");

  // the pipe only pushes back when the output is full and stalled
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !position_ready_o |-> result_valid_o && !result_ready_i)
    else $error("input stalled without output back-pressure");

  // kernel value lies in [0, 1]
  a_value_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !kernel_value_o[OutW-1] && kernel_value_o <= OneQ13)
    else $error("kernel value out of range");

  // with the sink ready throughout, an accepted beat moves through every stage unstalled and comes out
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(in_beat, 5) && $past(rst_ni, 1) && $past(rst_ni, 2) && $past(rst_ni, 3)
      && $past(rst_ni, 4) && $past(rst_ni, 5) && $past(result_ready_i, 1)
      && $past(result_ready_i, 2) && $past(result_ready_i, 3)
      && $past(result_ready_i, 4) |-> result_valid_o)
    else $error("result beat late");

endmodule

bind bspline_kernel_eval bke_checker u_bke_checker (.*);

// File: tb/tb_bspline_kernel_eval.sv
// tb_bspline_kernel_eval: self-checking testbench for the b-spline kernel evaluator
// drives position beats, predicts value and both derivatives, checks every result beat
// depends on bke_pkg and bspline_kernel_eval
`timescale 1ns / 100ps

module tb_bspline_kernel_eval;
  import bke_pkg::*;

  // pipeline depth given at the head of the block, plus a little slack
  localparam int PipeDepth = 5;
  localparam int SettleCycles = PipeDepth + 3;
  // q3.12 breakpoints used by the predictor
  localparam longint PHalf = 2048;
  localparam longint POne = 4096;
  localparam longint PThreeHalf = 6144;
  localparam longint PTwo = 8192;
  // q2.13 unit
  localparam longint QUnit = 8192;

  typedef struct packed {
    logic signed [OutW-1:0] kernel_value;
    logic signed [OutW-1:0] first_derivative;
    logic signed [OutW-1:0] second_derivative;
  } kernel_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   spline_order_we_i;
  logic [OrdW-1:0]        spline_order_i;
  logic                   position_valid_i;
  logic                   position_ready_o;
  logic signed [PosW-1:0] position_i;
  logic                   result_valid_o;
  logic                   result_ready_i;
  logic signed [OutW-1:0] kernel_value_o;
  logic signed [OutW-1:0] first_derivative_o;
  logic signed [OutW-1:0] second_derivative_o;

  // expected result beats, oldest first
  kernel_t expected_kernels[$];
  // shadow of the order register as the block should hold it
  order_e  order_setting;
  int      err_count;
  // when set, that side runs at full rate
  bit      gaps_off;
  bit      stalls_off;

  bspline_kernel_eval u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .spline_order_we_i   (spline_order_we_i),
    .spline_order_i      (spline_order_i),
    .position_valid_i    (position_valid_i),
    .position_ready_o    (position_ready_o),
    .position_i          (position_i),
    .result_valid_o      (result_valid_o),
    .result_ready_i      (result_ready_i),
    .kernel_value_o      (kernel_value_o),
    .first_derivative_o  (first_derivative_o),
    .second_derivative_o (second_derivative_o)
  );

  // 8 ns clock
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // generous overall limit, far beyond the slowest correct run
  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // n / d to nearest, ties away from zero, d positive
  function automatic longint round_div(longint n, longint d);
    if (n >= 0) begin
      return (n + d / 2) / d;
    end
    return -((-n + d / 2) / d);
  endfunction

  function automatic logic signed [OutW-1:0] clamp_q13(longint v);
    if (v > 32767) begin
      return 16'sh7fff;
    end
    if (v < -32768) begin
      return 16'sh8000;
    end
    return v[OutW-1:0];
  endfunction

  // kernel value and derivatives at a q3.12 position, all in q2.13
  function automatic kernel_t eval_kernel(order_e ord, logic signed [PosW-1:0] pos);
    longint x, v, w, kv, d1, d2;
    longint cube_den;
    kernel_t res;
    x = pos;
    kv = 0;
    d1 = 0;
    d2 = 0;
    cube_den = 3 * (longint'(1) << 24);
    case (ord)
      ORDER_LINEAR: begin
        // tent: rising on [-1,0), falling on [0,1), flat second derivative
        if (x >= -POne && x < 0) begin
          kv = (x + POne) * 2;
          d1 = QUnit;
        end else if (x >= 0 && x < POne) begin
          kv = (POne - x) * 2;
          d1 = -QUnit;
        end
      end
      ORDER_QUAD: begin
        // three parabolic pieces split at +-0.5, outer ones (|x| - 1.5)^2 / 2
        if (x >= -PThreeHalf && x < -PHalf) begin
          kv = round_div(x * x + 3 * POne * x + 9216 * POne, POne);
          d1 = (x + PThreeHalf) * 2;
          d2 = QUnit;
        end else if (x >= -PHalf && x < PHalf) begin
          kv = round_div(PThreeHalf * PHalf - x * x, PHalf);
          d1 = -4 * x;
          d2 = -2 * QUnit;
        end else if (x >= PHalf && x < PThreeHalf) begin
          kv = round_div(x * x - 3 * POne * x + 9216 * POne, POne);
          d1 = (x - PThreeHalf) * 2;
          d2 = QUnit;
        end
      end
      ORDER_CUBIC: begin
        v = (x < 0) ? -x : x;
        if (v < POne) begin
          // centre piece, constant term exactly two thirds
          kv = round_div(3 * v * v * v - 3 * v * v * PTwo + (longint'(1) << 38), cube_den);
          d2 = 6 * v - 2 * QUnit;
        end else if (v < PTwo) begin
          w = PTwo - v;
          kv = round_div(w * w * w, cube_den);
          d2 = w * 2;
        end
        // odd derivative keeps its own interval ends: [0,1] closed on the right
        if (x >= 0 && x <= POne) begin
          d1 = round_div(3 * x * x - 4 * POne * x, POne);
        end else if (x >= -POne && x < 0) begin
          d1 = round_div(-3 * x * x - 4 * POne * x, POne);
        end else if (x > POne && x < PTwo) begin
          d1 = round_div(-(x - PTwo) * (x - PTwo), POne);
        end else if (x < -POne && x > -PTwo) begin
          d1 = round_div((x + PTwo) * (x + PTwo), POne);
        end
      end
      default: ;
    endcase
    res.kernel_value = clamp_q13(kv);
    res.first_derivative = clamp_q13(d1);
    res.second_derivative = clamp_q13(d2);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // result side: stalls and checking
  // ---------------------------------------------------------------------------

  // idle length: mostly short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  // ready runs high for a while, then drops for a random stall
  initial begin
    int hold;
    hold = 0;
    result_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold == 0) begin
        if (!stalls_off && $urandom_range(0, 2) == 0) begin
          result_ready_i <= 1'b0;
          hold = idle_len();
        end else begin
          result_ready_i <= 1'b1;
          hold = $urandom_range(1, 8);
        end
      end else begin
        hold--;
      end
    end
  end

  task automatic check_field(string label, logic signed [OutW-1:0] want,
                             logic signed [OutW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
      err_count++;
    end
  endtask

  // every result beat is matched against the oldest prediction
  always @(posedge clk_i) begin
    kernel_t want;
    if (rst_ni && result_valid_o && result_ready_i) begin
      if (expected_kernels.size() == 0) begin
        $display("%0t: result beat with nothing expected, actual %0d %0d %0d", $time,
                 kernel_value_o, first_derivative_o, second_derivative_o);
        err_count++;
      end else begin
        want = expected_kernels.pop_front();
        check_field("kernel_value", want.kernel_value, kernel_value_o);
        check_field("first_derivative", want.first_derivative, first_derivative_o);
        check_field("second_derivative", want.second_derivative, second_derivative_o);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // position side
  // ---------------------------------------------------------------------------

  // one position beat; valid stays up afterwards so a following beat can go
  // back to back, wait_drained lowers it
  task automatic send_position(logic signed [PosW-1:0] pos);
    int gap;
    gap = 0;
    if (!gaps_off && $urandom_range(0, 1) == 0) begin
      gap = idle_len();
    end
    @(negedge clk_i);
    if (gap > 0) begin
      position_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    position_valid_i <= 1'b1;
    position_i <= pos;
    do begin
      @(posedge clk_i);
    end while (!position_ready_o);
    expected_kernels.push_back(eval_kernel(order_setting, pos));
  endtask

  // lower valid, wait for every outstanding result, then let the pipe settle
  task automatic wait_drained();
    @(negedge clk_i);
    position_valid_i <= 1'b0;
    while (expected_kernels.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // order writes only with the pipe empty
  task automatic set_order(order_e ord);
    wait_drained();
    @(negedge clk_i);
    spline_order_we_i <= 1'b1;
    spline_order_i <= ord;
    @(negedge clk_i);
    spline_order_we_i <= 1'b0;
    order_setting = ord;
  endtask

  // half around the support, some at or next to a breakpoint, some anywhere
  function automatic logic signed [PosW-1:0] pick_position();
    int breakpoints[9];
    int r;
    breakpoints = '{0, 2048, -2048, 4096, -4096, 6144, -6144, 8192, -8192};
    r = $urandom_range(0, 9);
    if (r < 5) begin
      return PosW'(int'($urandom_range(0, 16800)) - 8400);
    end
    if (r < 7) begin
      return PosW'(breakpoints[$urandom_range(0, 8)] + int'($urandom_range(0, 6)) - 3);
    end
    return PosW'($urandom);
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // cubic straight out of reset: extreme codes, centre, both edges of each piece
  task automatic test_reset_order();
    logic signed [PosW-1:0] points[10];
    points = '{-16'sd32768, 16'sd32767, 16'sd0, 16'sd4096, -16'sd4096,
               16'sd4095, 16'sd4097, 16'sd8192, -16'sd8192, -16'sd8191};
    foreach (points[i]) send_position(points[i]);
  endtask

  // piece boundaries of quadratic and linear, then order zero
  task automatic test_directed_breakpoints();
    logic signed [PosW-1:0] quad_points[8];
    logic signed [PosW-1:0] lin_points[6];
    quad_points = '{-16'sd6144, -16'sd6145, -16'sd2048, -16'sd2049,
                    16'sd2048, 16'sd2047, 16'sd6144, 16'sd6143};
    lin_points = '{-16'sd4096, -16'sd4097, -16'sd1, 16'sd0, 16'sd4095, 16'sd4096};
    set_order(ORDER_QUAD);
    foreach (quad_points[i]) send_position(quad_points[i]);
    set_order(ORDER_LINEAR);
    foreach (lin_points[i]) send_position(lin_points[i]);
    set_order(ORDER_NONE);
    send_position(16'sd0);
    send_position(16'sd1234);
  endtask

  // random positions under one order
  task automatic test_order_sweep(order_e ord, int count);
    set_order(ord);
    repeat (count) send_position(pick_position());
  endtask

  // both sides at full rate, no gaps and no stalls
  task automatic test_full_rate(int count);
    set_order(ORDER_QUAD);
    gaps_off = 1'b1;
    stalls_off = 1'b1;
    repeat (count) send_position(pick_position());
    wait_drained();
    gaps_off = 1'b0;
    stalls_off = 1'b0;
  endtask

  // sender holds off until every result has come back, then resumes
  task automatic test_drain_pause(int count);
    set_order(ORDER_LINEAR);
    repeat (count / 2) send_position(pick_position());
    wait_drained();
    repeat (count - count / 2) send_position(pick_position());
  endtask

  // short bursts, each under a randomly picked order, extremes included
  task automatic test_order_hopping(int bursts, int per_burst);
    repeat (bursts) begin
      test_order_sweep(order_e'($urandom_range(0, 3)), per_burst);
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    err_count = 0;
    gaps_off = 1'b0;
    stalls_off = 1'b0;
    order_setting = OrderReset;
    rst_ni = 1'b0;
    spline_order_we_i = 1'b0;
    spline_order_i = ORDER_CUBIC;
    position_valid_i = 1'b0;
    position_i = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_order();
    test_directed_breakpoints();
    test_order_sweep(ORDER_CUBIC, 250);
    test_order_sweep(ORDER_QUAD, 230);
    test_order_sweep(ORDER_LINEAR, 230);
    test_order_sweep(ORDER_NONE, 60);
    test_full_rate(150);
    test_drain_pause(80);
    test_order_hopping(8, 25);

    wait_drained();
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/bke_pkg.sv
sv/bspline_kernel_eval.sv
sv/bke_checker.sv
tb/tb_bspline_kernel_eval.sv
